// ===== src/pii_pattern_scanner_assert.svh =====
// assertion macros used by the checker file
`ifndef PII_PATTERN_SCANNER_ASSERT_SVH
`define PII_PATTERN_SCANNER_ASSERT_SVH

// same-cycle implication, quiet while reset is asserted
`define PPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// next-cycle implication, quiet while reset is asserted
`define PPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ===== src/pps_pkg.sv =====
`default_nettype none

package pps_pkg;

	localparam int WinDepth = 12;
	localparam int ShapeLen = 11;
	localparam int CountW = 5;
	localparam int CfgW = 5;

	localparam logic [CountW-1:0] RunSat = 5'd20;
	localparam logic [CfgW-1:0] CardMinRst = 5'd13;
	localparam logic [CfgW-1:0] CardMaxRst = 5'd19;

	// configuration register indexes
	localparam logic CfgCardMin = 1'b0;
	localparam logic CfgCardMax = 1'b1;

	// verdict codes
	localparam logic [1:0] VerdictClean = 2'd0;
	localparam logic [1:0] VerdictSsn = 2'd1;
	localparam logic [1:0] VerdictCard = 2'd2;

	typedef enum logic [1:0] {
		CLS_OTHER = 2'd0,
		CLS_DIGIT = 2'd1,
		CLS_DASH = 2'd2,
		CLS_SPACE = 2'd3
	} cls_t;

	typedef cls_t [WinDepth-1:0] win_t;

	// expected classes, newest first
	localparam cls_t SsnShape [ShapeLen] = '{
		CLS_DIGIT, CLS_DIGIT, CLS_DIGIT, CLS_DIGIT, CLS_DASH,
		CLS_DIGIT, CLS_DIGIT, CLS_DASH, CLS_DIGIT, CLS_DIGIT, CLS_DIGIT
	};

	function automatic cls_t classify(input logic [7:0] b);
		cls_t c;
		if (b >= 8'h30 && b <= 8'h39) begin
			c = CLS_DIGIT;
		end else if (b == 8'h2d) begin
			c = CLS_DASH;
		end else if (b == 8'h20) begin
			c = CLS_SPACE;
		end else begin
			c = CLS_OTHER;
		end
		return c;
	endfunction

	// shape in the newest slots, non-digit just before it
	function automatic logic holds_ssn(input win_t w);
		logic hit;
		hit = (w[WinDepth-1] != CLS_DIGIT);
		for (int k = 0; k < ShapeLen; k++) begin
			hit = hit && (w[k] == SsnShape[k]);
		end
		return hit;
	endfunction

	function automatic logic card_hit(
		input logic [CountW-1:0] cnt,
		input logic [CfgW-1:0] min_d,
		input logic [CfgW-1:0] max_d
	);
		return (cnt != '0) && (cnt >= min_d) && (cnt <= max_d);
	endfunction

endpackage

`default_nettype wire

// ===== src/pii_pattern_scanner.sv =====
// pii_pattern_scanner: flags ssn-shaped and card-number-shaped text in a byte stream
// one byte per cycle while no verdict is stalled; bytes flow back to back, no gaps needed
// the verdict is registered and valid in the cycle after the transfer of the last byte of a message
// a waiting verdict holds off new bytes only while the output register is full and stalled
// reset (arst_n low, asynchronous) clears the window, run counter and flags,
// empties the output register and loads card limits of 13 and 19 digits
`default_nettype none

module pii_pattern_scanner (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration write port
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [4:0] cfg_data,
	// byte channel
	input  wire logic       char_valid,
	output logic            char_ready,
	input  wire logic [7:0] char_byte,
	input  wire logic       last_byte,
	// verdict channel
	output logic            verdict_valid,
	input  wire logic       verdict_ready,
	output logic [1:0]      verdict
);

	// card digit limits
	logic [pps_pkg::CfgW-1:0] card_min_q;
	logic [pps_pkg::CfgW-1:0] card_max_q;

	// scan state
	pps_pkg::win_t window_q;
	logic [pps_pkg::CountW-1:0] run_cnt_q;
	logic ssn_seen_q;
	logic card_seen_q;

	// result register
	logic verdict_valid_q;
	logic [1:0] verdict_q;

	// next-state logic
	pps_pkg::cls_t cls;
	pps_pkg::win_t window_nxt;
	logic [pps_pkg::CountW-1:0] run_cnt_nxt;
	logic ssn_nxt;
	logic card_nxt;
	logic ssn_final;
	logic card_final;
	logic byte_xfer;

	// the output register frees up in the same cycle its verdict is taken
	assign char_ready = !verdict_valid_q || verdict_ready;
	assign byte_xfer = char_valid && char_ready;

	always_comb begin
		cls = pps_pkg::classify(char_byte);

		// pattern that ended on the previous byte, closed off by a non-digit now
		ssn_nxt = ssn_seen_q || ((cls != pps_pkg::CLS_DIGIT) && pps_pkg::holds_ssn(window_q));

		// newest class enters slot 0, the oldest drops out
		window_nxt[pps_pkg::WinDepth-1:1] = window_q[pps_pkg::WinDepth-2:0];
		window_nxt[0] = cls;

		card_nxt = card_seen_q;
		run_cnt_nxt = run_cnt_q;
		case (cls)
			pps_pkg::CLS_DIGIT: begin
				if (run_cnt_q < pps_pkg::RunSat) begin
					run_cnt_nxt = run_cnt_q + 1'b1;
				end
			end
			pps_pkg::CLS_OTHER: begin
				// anything but digit, space or dash ends the run
				card_nxt = card_seen_q || pps_pkg::card_hit(run_cnt_q, card_min_q, card_max_q);
				run_cnt_nxt = '0;
			end
			default: begin
				// separators keep the run going
			end
		endcase

		// message end closes both the pattern and the current run
		ssn_final = ssn_nxt || pps_pkg::holds_ssn(window_nxt);
		card_final = card_nxt || pps_pkg::card_hit(run_cnt_nxt, card_min_q, card_max_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			card_min_q <= pps_pkg::CardMinRst;
			card_max_q <= pps_pkg::CardMaxRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pps_pkg::CfgCardMin: card_min_q <= cfg_data;
				pps_pkg::CfgCardMax: card_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '{default: pps_pkg::CLS_OTHER};
			run_cnt_q <= '0;
			ssn_seen_q <= 1'b0;
			card_seen_q <= 1'b0;
		end else if (byte_xfer) begin
			if (last_byte) begin
				// start the next message from a clean slate
				window_q <= '{default: pps_pkg::CLS_OTHER};
				run_cnt_q <= '0;
				ssn_seen_q <= 1'b0;
				card_seen_q <= 1'b0;
			end else begin
				window_q <= window_nxt;
				run_cnt_q <= run_cnt_nxt;
				ssn_seen_q <= ssn_nxt;
				card_seen_q <= card_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (byte_xfer && last_byte) begin
			verdict_valid_q <= 1'b1;
		end else if (verdict_ready) begin
			verdict_valid_q <= 1'b0;
		end
	end

	// ssn takes priority over card
	always_ff @(posedge clk) begin
		if (byte_xfer && last_byte) begin
			if (ssn_final) begin
				verdict_q <= pps_pkg::VerdictSsn;
			end else if (card_final) begin
				verdict_q <= pps_pkg::VerdictCard;
			end else begin
				verdict_q <= pps_pkg::VerdictClean;
			end
		end
	end

	assign verdict_valid = verdict_valid_q;
	assign verdict = verdict_q;

endmodule

`default_nettype wire

// ===== src/pii_pattern_scanner_chk.sv =====
`default_nettype none

`include "pii_pattern_scanner_assert.svh"

module pii_pattern_scanner_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       char_valid,
	input wire logic       char_ready,
	input wire logic       last_byte,
	input wire logic       verdict_valid,
	input wire logic       verdict_ready,
	input wire logic [1:0] verdict
);

	logic last_xfer;
	logic stalled;

	assign last_xfer = char_valid && char_ready && last_byte;
	assign stalled = verdict_valid && !verdict_ready;

	// only the three defined verdict codes leave the block
	`PPS_ASSERT_IMP(a_verdict_code, clk, arst_n, verdict_valid, verdict <= pps_pkg::VerdictCard)

	// a verdict only appears after the last byte of a message has transferred
	`PPS_ASSERT_IMP(a_verdict_cause, clk, arst_n, $rose(verdict_valid), $past(last_xfer))

	// a stalled verdict blocks further bytes
	`PPS_ASSERT_IMP(a_stall_backpressure, clk, arst_n, stalled, !char_ready)

	// a stalled verdict holds
	`PPS_ASSERT_NXT(a_verdict_hold, clk, arst_n, stalled, verdict_valid && $stable(verdict))

endmodule

bind pii_pattern_scanner pii_pattern_scanner_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.char_valid(char_valid),
	.char_ready(char_ready),
	.last_byte(last_byte),
	.verdict_valid(verdict_valid),
	.verdict_ready(verdict_ready),
	.verdict(verdict)
);

`default_nettype wire
